@@ sv/v3an_pkg.sv @@
// ----------------------------------------------------------------------------
// v3an_pkg: shared types and defaults of the vector ALU
// Mode codes, default widths and the control word that travels with each
// transaction down the pipeline.
// ----------------------------------------------------------------------------
package v3an_pkg;

    localparam int COMP_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [2:0] {
        MODE_MUL = 3'd0,
        MODE_DIV = 3'd1,
        MODE_ADD = 3'd2,
        MODE_SUB = 3'd3,
        MODE_NRM = 3'd4
    } t_mode;

    // Control word carried alongside the data of one transaction.
    typedef struct packed {
        logic       valid;
        logic [2:0] mode;
        logic [2:0] neg;    // sign of each result component
        logic [2:0] bzero;  // component of B is zero
        logic       azero;  // vector A is all zero
        logic       qsat;   // saturation from multiply, add or subtract
    } t_ctl;

endpackage

@@ sv/v3an_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// v3an_sqrt_cell: one bit of the pipelined square root
// Decides root bit B from the running remainder and passes the transaction on.
// ----------------------------------------------------------------------------
module v3an_sqrt_cell #(
    parameter int W  = 32,
    parameter int B  = 0,
    parameter int PW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  v3an_pkg::t_ctl        i_ctl,
    input  logic [PW-1:0]         i_pay,
    input  logic [2*W-1:0]        i_rem,
    input  logic [W-1:0]          i_root,
    output v3an_pkg::t_ctl        o_ctl,
    output logic [PW-1:0]         o_pay,
    output logic [2*W-1:0]        o_rem,
    output logic [W-1:0]          o_root
);
    import v3an_pkg::*;

    t_ctl           r_ctl;
    logic [PW-1:0]  r_pay;
    logic [2*W-1:0] r_rem;
    logic [W-1:0]   r_root;
    logic [2*W-1:0] w_trial;
    logic [2*W-1:0] n_rem;
    logic [W-1:0]   n_root;

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    assign w_trial = ({{W{1'b0}}, i_root} << (B + 1)) + ((2*W)'(1) << (2 * B));

    always_comb begin
        if (w_trial <= i_rem) begin
            n_rem  = i_rem - w_trial;
            n_root = i_root | (W'(1) << B);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_pay  <= i_pay;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_ctl  = r_ctl;
    assign o_pay  = r_pay;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

@@ sv/v3an_div_cell.sv @@
// ----------------------------------------------------------------------------
// v3an_div_cell: one quotient bit of three restoring dividers
// Produces quotient bit B for each component and passes the transaction on.
// ----------------------------------------------------------------------------
module v3an_div_cell #(
    parameter int W  = 32,
    parameter int QW = 48,
    parameter int B  = 0,
    parameter int PW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  v3an_pkg::t_ctl        i_ctl,
    input  logic [PW-1:0]         i_pay,
    input  logic [2:0][QW-1:0]    i_num,
    input  logic [2:0][W-1:0]     i_den,
    input  logic [2:0][W-1:0]     i_rem,
    input  logic [2:0][QW-1:0]    i_quo,
    output v3an_pkg::t_ctl        o_ctl,
    output logic [PW-1:0]         o_pay,
    output logic [2:0][QW-1:0]    o_num,
    output logic [2:0][W-1:0]     o_den,
    output logic [2:0][W-1:0]     o_rem,
    output logic [2:0][QW-1:0]    o_quo
);
    import v3an_pkg::*;

    t_ctl                r_ctl;
    logic [PW-1:0]       r_pay;
    logic [2:0][QW-1:0]  r_num;
    logic [2:0][W-1:0]   r_den;
    logic [2:0][W-1:0]   r_rem;
    logic [2:0][QW-1:0]  r_quo;
    logic [2:0][W-1:0]   n_rem;
    logic [2:0][QW-1:0]  n_quo;
    logic [W:0]          w_sh;

    always_comb begin
        w_sh = '0;
        for (int k = 0; k < 3; k++) begin
            w_sh = {i_rem[k], i_num[k][B]};
            if (w_sh >= {1'b0, i_den[k]}) begin
                n_rem[k] = W'(w_sh - {1'b0, i_den[k]});
                n_quo[k] = i_quo[k] | (QW'(1) << B);
            end else begin
                n_rem[k] = w_sh[W-1:0];
                n_quo[k] = i_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_pay <= i_pay;
        r_num <= i_num;
        r_den <= i_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_ctl = r_ctl;
    assign o_pay = r_pay;
    assign o_num = r_num;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

@@ sv/vec3_alu_normalize.sv @@
// ----------------------------------------------------------------------------
// vec3_alu_normalize: pipelined three-component fixed-point vector ALU
// Component-wise multiply, divide, add and subtract of two vectors, or
// normalization of vector A, with saturation to the signed component range.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is issued by raising start with the mode and both vectors on
// the input ports; it is taken at any clock edge where start is high and busy
// is low. The block is a fully pipelined row of cells and never stalls, so
// busy is always low and a new transaction may be issued on every cycle.
// Each transaction returns exactly one result, presented for a single cycle
// with o_valid high, in issue order. The receiver cannot stall the block and
// must take the result in that cycle.
// A transaction passes through the input register, stages 1 and 2, the square
// root chain (one cell per root bit), the divider chain (one cell per
// quotient bit) and the output register. Every mode takes the same path, so
// throughput is one transaction per cycle in all modes.
// A synchronous reset clears every valid bit in the pipeline; transactions
// in flight are dropped and no result appears until new ones are issued.
// ----------------------------------------------------------------------------
module vec3_alu_normalize #(
    parameter int COMP_WIDTH = v3an_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = v3an_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_mode,
    input  logic signed [COMP_WIDTH-1:0] i_a_x,
    input  logic signed [COMP_WIDTH-1:0] i_a_y,
    input  logic signed [COMP_WIDTH-1:0] i_a_z,
    input  logic signed [COMP_WIDTH-1:0] i_b_x,
    input  logic signed [COMP_WIDTH-1:0] i_b_y,
    input  logic signed [COMP_WIDTH-1:0] i_b_z,
    output logic                         o_valid,
    output logic signed [COMP_WIDTH-1:0] o_r_x,
    output logic signed [COMP_WIDTH-1:0] o_r_y,
    output logic signed [COMP_WIDTH-1:0] o_r_z,
    output logic                         o_saturated,
    output logic                         o_divide_by_zero
);
    import v3an_pkg::*;

    localparam int W   = COMP_WIDTH;
    localparam int QW  = COMP_WIDTH + FRAC_BITS;
    localparam int SPW = 9 * COMP_WIDTH;
    localparam int DPW = 3 * COMP_WIDTH;
    localparam int LAT = COMP_WIDTH + QW + 4;

    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE    = W'(1) << FRAC_BITS;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // ---------------- Stage 0: input register ----------------
    logic                r0_valid;
    logic [2:0]          r0_mode;
    logic [2:0][W-1:0]   r0_a;
    logic [2:0][W-1:0]   r0_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start && !busy;
        end
        if (start && !busy) begin
            r0_mode <= i_mode;
            r0_a    <= {i_a_z, i_a_y, i_a_x};
            r0_b    <= {i_b_z, i_b_y, i_b_x};
        end
    end

    // ---------------- Stage 1: magnitudes, products, add/subtract -------
    t_ctl                n1_ctl;
    logic [2:0][W-1:0]   n1_amag;
    logic [2:0][W-1:0]   n1_bmag;
    logic [2:0][2*W-1:0] n1_prod;
    logic [2:0][W-1:0]   n1_addres;
    logic                n1_addsat;
    logic [W-1:0]        w1_opnd;
    logic [W:0]          w1_sum;
    logic                w1_aneg;
    logic                w1_bneg;

    always_comb begin
        n1_ctl       = '0;
        n1_ctl.valid = r0_valid;
        n1_ctl.mode  = r0_mode;
        n1_addsat    = 1'b0;
        w1_opnd      = '0;
        w1_sum       = '0;
        w1_aneg      = 1'b0;
        w1_bneg      = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w1_aneg      = r0_a[k][W-1];
            w1_bneg      = r0_b[k][W-1];
            n1_amag[k]   = w1_aneg ? W'(-r0_a[k]) : r0_a[k];
            n1_bmag[k]   = w1_bneg ? W'(-r0_b[k]) : r0_b[k];
            n1_ctl.neg[k]   = (r0_mode == MODE_NRM) ? w1_aneg : (w1_aneg ^ w1_bneg);
            n1_ctl.bzero[k] = (r0_b[k] == '0);
            w1_opnd    = (r0_mode == MODE_NRM) ? n1_amag[k] : n1_bmag[k];
            n1_prod[k] = (2*W)'(n1_amag[k]) * (2*W)'(w1_opnd);
            if (r0_mode == MODE_SUB) begin
                w1_sum = {r0_a[k][W-1], r0_a[k]} - {r0_b[k][W-1], r0_b[k]};
            end else begin
                w1_sum = {r0_a[k][W-1], r0_a[k]} + {r0_b[k][W-1], r0_b[k]};
            end
            if (w1_sum[W] != w1_sum[W-1]) begin
                n1_addres[k] = w1_sum[W] ? MINNEG : MAXPOS;
                n1_addsat    = 1'b1;
            end else begin
                n1_addres[k] = w1_sum[W-1:0];
            end
        end
        n1_ctl.azero = (r0_a == '0);
        n1_ctl.qsat  = n1_addsat;
    end

    t_ctl                r1_ctl;
    logic [2:0][W-1:0]   r1_amag;
    logic [2:0][W-1:0]   r1_bmag;
    logic [2:0][2*W-1:0] r1_prod;
    logic [2:0][W-1:0]   r1_addres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= n1_ctl;
        end
        r1_amag   <= n1_amag;
        r1_bmag   <= n1_bmag;
        r1_prod   <= n1_prod;
        r1_addres <= n1_addres;
    end

    // ---------------- Stage 2: multiply clamp, sum of squares ----------
    // The multiply result is the product shifted down by the fraction width,
    // clamped by magnitude and then given its sign.
    t_ctl                n2_ctl;
    logic [2:0][W-1:0]   n2_quick;
    logic [2*W-1:0]      n2_sum;
    logic [2*W-1:0]      w2_psh;
    logic [W-1:0]        w2_lim;
    logic [W-1:0]        w2_mag;
    logic                w2_msat;

    always_comb begin
        n2_ctl  = r1_ctl;
        w2_msat = 1'b0;
        w2_psh  = '0;
        w2_lim  = '0;
        w2_mag  = '0;
        for (int k = 0; k < 3; k++) begin
            w2_psh = r1_prod[k] >> FRAC_BITS;
            w2_lim = r1_ctl.neg[k] ? MINNEG : MAXPOS;
            if (w2_psh > {{W{1'b0}}, w2_lim}) begin
                w2_mag  = w2_lim;
                w2_msat = 1'b1;
            end else begin
                w2_mag = w2_psh[W-1:0];
            end
            unique case (r1_ctl.mode)
                MODE_MUL: n2_quick[k] = r1_ctl.neg[k] ? W'(-w2_mag) : w2_mag;
                MODE_ADD,
                MODE_SUB: n2_quick[k] = r1_addres[k];
                default:  n2_quick[k] = '0;
            endcase
        end
        unique case (r1_ctl.mode)
            MODE_MUL: n2_ctl.qsat = w2_msat;
            MODE_ADD,
            MODE_SUB: n2_ctl.qsat = r1_ctl.qsat;
            default:  n2_ctl.qsat = 1'b0;
        endcase
        n2_sum = r1_prod[0] + r1_prod[1] + r1_prod[2];
    end

    t_ctl                r2_ctl;
    logic [SPW-1:0]      r2_pay;
    logic [2*W-1:0]      r2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= n2_ctl;
        end
        r2_pay <= {n2_quick, r1_bmag, r1_amag};
        r2_sum <= n2_sum;
    end

    // ---------------- Square root chain: one cell per root bit ----------
    t_ctl               w_sq_ctl  [0:W];
    logic [SPW-1:0]     w_sq_pay  [0:W];
    logic [2*W-1:0]     w_sq_rem  [0:W];
    logic [W-1:0]       w_sq_root [0:W];

    assign w_sq_ctl[0]  = r2_ctl;
    assign w_sq_pay[0]  = r2_pay;
    assign w_sq_rem[0]  = r2_sum;
    assign w_sq_root[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_sqrt
        v3an_sqrt_cell #(
            .W  (W),
            .B  (W - 1 - g),
            .PW (SPW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_sq_ctl[g]),
            .i_pay   (w_sq_pay[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .o_ctl   (w_sq_ctl[g+1]),
            .o_pay   (w_sq_pay[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1])
        );
    end

    // ---------------- Divider chain: one cell per quotient bit ----------
    // Normalize divides by the root; divide mode divides by the magnitude of B.
    logic [2:0][W-1:0]  w_amag;
    logic [2:0][W-1:0]  w_bmag;
    logic [2:0][QW-1:0] w_num0;
    logic [2:0][W-1:0]  w_den0;

    assign w_amag = w_sq_pay[W][3*W-1:0];
    assign w_bmag = w_sq_pay[W][6*W-1:3*W];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_num0[k] = {w_amag[k], {FRAC_BITS{1'b0}}};
            w_den0[k] = (w_sq_ctl[W].mode == MODE_NRM) ? w_sq_root[W] : w_bmag[k];
        end
    end

    t_ctl               w_dv_ctl [0:QW];
    logic [DPW-1:0]     w_dv_pay [0:QW];
    logic [2:0][QW-1:0] w_dv_num [0:QW];
    logic [2:0][W-1:0]  w_dv_den [0:QW];
    logic [2:0][W-1:0]  w_dv_rem [0:QW];
    logic [2:0][QW-1:0] w_dv_quo [0:QW];

    assign w_dv_ctl[0] = w_sq_ctl[W];
    assign w_dv_pay[0] = w_sq_pay[W][SPW-1:6*W];
    assign w_dv_num[0] = w_num0;
    assign w_dv_den[0] = w_den0;
    assign w_dv_rem[0] = '0;
    assign w_dv_quo[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        v3an_div_cell #(
            .W  (W),
            .QW (QW),
            .B  (QW - 1 - g),
            .PW (DPW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_dv_ctl[g]),
            .i_pay   (w_dv_pay[g]),
            .i_num   (w_dv_num[g]),
            .i_den   (w_dv_den[g]),
            .i_rem   (w_dv_rem[g]),
            .i_quo   (w_dv_quo[g]),
            .o_ctl   (w_dv_ctl[g+1]),
            .o_pay   (w_dv_pay[g+1]),
            .o_num   (w_dv_num[g+1]),
            .o_den   (w_dv_den[g+1]),
            .o_rem   (w_dv_rem[g+1]),
            .o_quo   (w_dv_quo[g+1])
        );
    end

    // ---------------- Output stage: clamp, zero cases, mode select -------
    t_ctl               w_f_ctl;
    logic [2:0][W-1:0]  w_f_quick;
    logic [2:0][W-1:0]  w_f_amag;
    logic [2:0][W-1:0]  n_res;
    logic               n_sat;
    logic               n_dz;
    logic [2:0][W-1:0]  w_qres;
    logic               w_qsat;
    logic [W-1:0]       w_lim;
    logic [W-1:0]       w_mag;

    assign w_f_ctl   = w_dv_ctl[QW];
    assign w_f_quick = w_dv_pay[QW];

    // The numerator is the magnitude of A shifted up by the fraction width.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_f_amag[k] = w_dv_num[QW][k][QW-1:FRAC_BITS];
        end
    end

    always_comb begin
        w_qsat = 1'b0;
        w_lim  = '0;
        w_mag  = '0;
        for (int k = 0; k < 3; k++) begin
            w_lim = w_f_ctl.neg[k] ? MINNEG : MAXPOS;
            if (w_dv_quo[QW][k] > {{FRAC_BITS{1'b0}}, w_lim}) begin
                w_mag  = w_lim;
                w_qsat = 1'b1;
            end else begin
                w_mag = w_dv_quo[QW][k][W-1:0];
            end
            w_qres[k] = w_f_ctl.neg[k] ? W'(-w_mag) : w_mag;
        end
    end

    always_comb begin
        n_res = '0;
        n_sat = 1'b0;
        n_dz  = 1'b0;
        unique case (w_f_ctl.mode)
            MODE_MUL, MODE_ADD, MODE_SUB: begin
                n_res = w_f_quick;
                n_sat = w_f_ctl.qsat;
            end
            MODE_DIV: begin
                // A zero divisor takes the limit on the side of the dividend, or zero when the dividend is zero.
                n_dz = |w_f_ctl.bzero;
                for (int k = 0; k < 3; k++) begin
                    if (w_f_ctl.bzero[k]) begin
                        if (w_f_amag[k] == '0) begin
                            n_res[k] = '0;
                        end else begin
                            n_res[k] = w_f_ctl.neg[k] ? MINNEG : MAXPOS;
                        end
                    end else begin
                        n_res[k] = w_qres[k];
                    end
                end
                // Only lanes with a nonzero divisor can saturate.
                n_sat = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    if (!w_f_ctl.bzero[k]) begin
                        n_sat = n_sat |
                            (w_dv_quo[QW][k] > {{FRAC_BITS{1'b0}},
                             (w_f_ctl.neg[k] ? MINNEG : MAXPOS)});
                    end
                end
            end
            MODE_NRM: begin
                if (w_f_ctl.azero) begin
                    n_res[2] = ONE;
                end else begin
                    n_res = w_qres;
                    n_sat = w_qsat;
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    logic              r_o_valid;
    logic [2:0]        r_o_mode;
    logic [2:0][W-1:0] r_o_res;
    logic              r_o_sat;
    logic              r_o_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_o_sat   <= 1'b0;
            r_o_dz    <= 1'b0;
        end else begin
            r_o_valid <= w_f_ctl.valid;
            r_o_sat   <= w_f_ctl.valid && n_sat;
            r_o_dz    <= w_f_ctl.valid && n_dz;
        end
        r_o_mode <= w_f_ctl.mode;
        r_o_res  <= n_res;
    end

    assign o_valid          = r_o_valid;
    assign o_r_x            = r_o_res[0];
    assign o_r_y            = r_o_res[1];
    assign o_r_z            = r_o_res[2];
    assign o_saturated      = r_o_sat;
    assign o_divide_by_zero = r_o_dz;

    // ---------------- Assertions ----------------
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted transaction did not produce a result in time");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted transaction");

    a_dz_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_divide_by_zero |-> (o_valid && r_o_mode == MODE_DIV))
        else $error("divide-by-zero flag outside a divide result");

endmodule
